// ===== sv/srts_pkg.sv =====
// Shared types and constants of the shortest-remaining-time scheduler.
// Used by srts_ctrl, srts_dp and the top level; depends on nothing else.
`default_nettype none

package srts_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int TIME_W     = 16;
  localparam int SLOT_W     = 4;
  localparam int CMD_W      = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic scan_start;
    logic scan_issue;
    logic pick_read;
    logic commit;
    logic out_zero;
    logic out_tick;
  } srts_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_last;
  } srts_stat_t;

endpackage

`default_nettype wire

// ===== sv/srts_ctrl.sv =====
// Controller state machine of the scheduler: request handshake, tick sequencing
// and the output valid flag. Depends on srts_pkg.
`default_nettype none

module srts_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               command,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output srts_pkg::srts_cmd_t           cmd,
  input  wire srts_pkg::srts_stat_t     stat
);
  import srts_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_PICK   = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_REPORT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;
  logic       accept;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_LOAD: begin
              cmd.load     = 1'b1;
              cmd.out_zero = 1'b1;
            end
            CMD_TICK: begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
            CMD_CLEAR: begin
              cmd.clear    = 1'b1;
              cmd.out_zero = 1'b1;
            end
            default: begin
              cmd.out_zero = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick_read = 1'b1;
        state_next    = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.out_tick = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_zero || cmd.out_tick) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/srts_dp.sv =====
// Datapath of the scheduler: slot memories, tick clock, serial minimum search
// and the result register. Depends on srts_pkg.
`default_nettype none

module srts_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire srts_pkg::srts_cmd_t               cmd,
  output srts_pkg::srts_stat_t                   stat,
  input  wire logic [srts_pkg::SLOT_W-1:0]       slot,
  input  wire logic [srts_pkg::TIME_W-1:0]       arrival_time,
  input  wire logic [srts_pkg::TIME_W-1:0]       burst_time,
  output logic                                   finished,
  output logic [srts_pkg::SLOT_W-1:0]            finished_slot,
  output logic [srts_pkg::TIME_W-1:0]            completion_time,
  output logic [srts_pkg::TIME_W-1:0]            waiting_time,
  output logic [srts_pkg::TIME_W-1:0]            turnaround_time,
  output logic [srts_pkg::SLOT_W-1:0]            ran_slot,
  output logic                                   cpu_idle
);
  import srts_pkg::*;

  logic [TIME_W-1:0] arrival_mem   [SLOT_COUNT];
  logic [TIME_W-1:0] remaining_mem [SLOT_COUNT];
  logic [TIME_W-1:0] burst_mem     [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid;

  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  best_idx;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  load_idx;
  logic [IDX_W-1:0]  rem_wa;
  logic              rd_live;
  logic              rd_ok;
  logic              found;
  logic              load_ok;
  logic              cand;
  logic              rem_we;
  logic              fin;
  logic [TIME_W-1:0] rd_rem;
  logic [TIME_W-1:0] rd_arr;
  logic [TIME_W-1:0] rd_bur;
  logic [TIME_W-1:0] best_rem;
  logic [TIME_W-1:0] clock_now;
  logic [TIME_W-1:0] done_time;
  logic [TIME_W-1:0] done_next;
  logic [TIME_W-1:0] tat;
  logic [TIME_W-1:0] tat_next;
  logic [TIME_W-1:0] wait_calc;
  logic [TIME_W-1:0] rem_wd;
  logic              rd_en;

  assign load_ok  = cmd.load && (32'(slot) < SLOT_COUNT);
  assign load_idx = IDX_W'(slot);
  assign rd_addr  = cmd.pick_read ? best_idx : scan_idx;
  assign rd_en    = cmd.scan_issue || cmd.pick_read;
  assign stat.scan_last = (scan_idx == IDX_W'(SLOT_COUNT - 1));

  // candidate: arrived, has work, strictly less than the best so far
  assign cand = rd_live && rd_ok && (rd_rem != '0) && (rd_arr <= clock_now) &&
                (!found || (rd_rem < best_rem));

  assign rem_we = load_ok || (cmd.commit && found);
  assign rem_wa = cmd.load ? load_idx : best_idx;
  assign rem_wd = cmd.load ? burst_time : best_rem - 1'b1;

  assign done_next = (clock_now == '1) ? clock_now : clock_now + 1'b1;
  assign tat_next  = (done_next > rd_arr) ? done_next - rd_arr : '0;
  assign wait_calc = (tat > rd_bur) ? tat - rd_bur : '0;
  assign fin       = found && (best_rem == TIME_W'(1));

  // slot memories
  always_ff @(posedge clk) begin
    if (load_ok) begin
      arrival_mem[load_idx] <= arrival_time;
      burst_mem[load_idx]   <= burst_time;
    end
    if (rem_we) begin
      remaining_mem[rem_wa] <= rem_wd;
    end
    if (rd_en) begin
      rd_arr <= arrival_mem[rd_addr];
      rd_rem <= remaining_mem[rd_addr];
      rd_bur <= burst_mem[rd_addr];
      rd_ok  <= slot_valid[rd_addr];
      rd_idx <= rd_addr;
    end
  end

  // control state: entry valid bits, clock, scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      clock_now  <= '0;
      rd_live    <= 1'b0;
    end else begin
      rd_live <= cmd.scan_issue;
      if (cmd.clear) begin
        slot_valid <= '0;
        clock_now  <= '0;
      end else begin
        if (load_ok) slot_valid[load_idx] <= 1'b1;
        if (cmd.commit) clock_now <= done_next;
      end
    end
  end

  // serial minimum search
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else begin
      if (cmd.scan_issue && !stat.scan_last) scan_idx <= scan_idx + 1'b1;
      if (cand) begin
        found    <= 1'b1;
        best_idx <= rd_idx;
        best_rem <= rd_rem;
      end
    end
  end

  // completion figures
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      done_time <= done_next;
      tat       <= tat_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_zero) begin
      finished        <= 1'b0;
      finished_slot   <= '0;
      completion_time <= '0;
      waiting_time    <= '0;
      turnaround_time <= '0;
      ran_slot        <= '0;
      cpu_idle        <= 1'b0;
    end else if (cmd.out_tick) begin
      finished        <= fin;
      finished_slot   <= fin ? SLOT_W'(best_idx) : '0;
      completion_time <= fin ? done_time : '0;
      waiting_time    <= fin ? wait_calc : '0;
      turnaround_time <= fin ? tat : '0;
      ran_slot        <= found ? SLOT_W'(best_idx) : '0;
      cpu_idle        <= !found;
    end
  end

endmodule

`default_nettype wire

// ===== sv/shortest_remaining_time_scheduler_top.sv =====
// Top level of the shortest-remaining-time scheduler: joins controller and
// datapath and carries the checks. Depends on srts_pkg, srts_ctrl, srts_dp.
//
// Use: each request on the input channel (in_valid / in_stall) carries a
// command. A load writes arrival and burst into a slot, a clear empties every
// slot and zeroes the tick clock, and a tick runs one unit of work on the
// arrived slot with the least remaining time, ties to the lowest slot.
// Every request gives exactly one result on the output channel
// (out_valid / out_stall); load, clear and unused codes give an all-zero one.
// Latency: a load or clear result is valid one cycle after acceptance, and the
// next request may be taken in that cycle. A tick reads the slot memories one
// slot per cycle, scanning every slot in turn, then drains the compare, makes
// one memory read of the chosen slot, one commit and one report, and returns
// to the idle step that takes the next request. Only one request is in work
// at a time.
// Reset: rst clears the clock, the slot valid bits and the output flag; slot
// memories need no clearing since an empty slot is marked by its valid bit.
// Stall: a stalled result holds in the output register; a finished tick
// waits in its report step and no new request is taken until the register
// frees.
`default_nettype none

module shortest_remaining_time_scheduler_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [srts_pkg::CMD_W-1:0]    command,
  input  wire logic [srts_pkg::SLOT_W-1:0]   slot,
  input  wire logic [srts_pkg::TIME_W-1:0]   arrival_time,
  input  wire logic [srts_pkg::TIME_W-1:0]   burst_time,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               finished,
  output logic [srts_pkg::SLOT_W-1:0]        finished_slot,
  output logic [srts_pkg::TIME_W-1:0]        completion_time,
  output logic [srts_pkg::TIME_W-1:0]        waiting_time,
  output logic [srts_pkg::TIME_W-1:0]        turnaround_time,
  output logic [srts_pkg::SLOT_W-1:0]        ran_slot,
  output logic                               cpu_idle
);
  import srts_pkg::*;

  srts_cmd_t  cmd;
  srts_stat_t stat;

  // sequence each request
  srts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // hold the slot table, search it and build the result
  srts_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .slot            (slot),
    .arrival_time    (arrival_time),
    .burst_time      (burst_time),
    .finished        (finished),
    .finished_slot   (finished_slot),
    .completion_time (completion_time),
    .waiting_time    (waiting_time),
    .turnaround_time (turnaround_time),
    .ran_slot        (ran_slot),
    .cpu_idle        (cpu_idle)
  );

`ifndef SYNTHESIS
  // a request is only taken when its result has somewhere to go
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (!out_valid || !out_stall))
    else $error("request accepted while output register blocked");

  // a tick occupies the block, so the next cycle takes no request
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (command == CMD_TICK)) |=> in_stall)
    else $error("request accepted during tick processing");

  // a completion always reports a running slot
  a_fin_not_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(finished && cpu_idle))
    else $error("result both finished and idle");

  // the finished slot is the one that ran
  a_fin_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && finished) |-> (finished_slot == ran_slot))
    else $error("finished slot differs from ran slot");
`endif

endmodule

`default_nettype wire

// ===== test/tb_shortest_remaining_time_scheduler_top.sv =====
// Self-checking bench for the shortest-remaining-time scheduler: drives load, tick and
// clear requests and checks every result against a tracked copy of the slot table.
// Depends on srts_pkg and shortest_remaining_time_scheduler_top.
`timescale 1ns / 100ps

// One result as the block reports it, fields in port order.
typedef struct packed {
  logic                            finished;
  logic [srts_pkg::SLOT_W-1:0]     finished_slot;
  logic [srts_pkg::TIME_W-1:0]     completion_time;
  logic [srts_pkg::TIME_W-1:0]     waiting_time;
  logic [srts_pkg::TIME_W-1:0]     turnaround_time;
  logic [srts_pkg::SLOT_W-1:0]     ran_slot;
  logic                            cpu_idle;
} sched_report_t;

// Tracks the slot table and tick clock, and queues the report each request should give.
class schedule_tracker;
  logic [srts_pkg::TIME_W-1:0] tick_clock;
  logic [srts_pkg::TIME_W-1:0] arrival_tab   [srts_pkg::SLOT_COUNT];
  logic [srts_pkg::TIME_W-1:0] remaining_tab [srts_pkg::SLOT_COUNT];
  logic [srts_pkg::TIME_W-1:0] burst_tab     [srts_pkg::SLOT_COUNT];
  sched_report_t               pending_reports [$];
  int unsigned                 mismatches;

  function new();
    wipe();
    mismatches = 0;
  endfunction

  function void wipe();
    tick_clock = '0;
    for (int i = 0; i < srts_pkg::SLOT_COUNT; i++) begin
      arrival_tab[i]   = '0;
      remaining_tab[i] = '0;
      burst_tab[i]     = '0;
    end
  endfunction

  function logic [srts_pkg::TIME_W-1:0] current_tick();
    return tick_clock;
  endfunction

  // Apply one accepted request to the table and queue the report it gives.
  function void note_request(logic [srts_pkg::CMD_W-1:0] cmd,
                             logic [srts_pkg::SLOT_W-1:0] slot_id,
                             logic [srts_pkg::TIME_W-1:0] arr,
                             logic [srts_pkg::TIME_W-1:0] bur);
    sched_report_t               rpt;
    int                          pick;
    logic [srts_pkg::TIME_W-1:0] done;
    logic [srts_pkg::TIME_W-1:0] span;
    rpt  = '0;
    pick = -1;
    if (cmd == srts_pkg::CMD_LOAD) begin
      if (int'(slot_id) < srts_pkg::SLOT_COUNT) begin
        arrival_tab[slot_id]   = arr;
        burst_tab[slot_id]     = bur;
        remaining_tab[slot_id] = bur;
      end
    end else if (cmd == srts_pkg::CMD_CLEAR) begin
      wipe();
    end else if (cmd == srts_pkg::CMD_TICK) begin
      // strict less-than keeps the lowest slot on a tie
      for (int i = 0; i < srts_pkg::SLOT_COUNT; i++) begin
        if (remaining_tab[i] != '0 && arrival_tab[i] <= tick_clock) begin
          if (pick < 0 || remaining_tab[i] < remaining_tab[pick]) pick = i;
        end
      end
      if (pick < 0) begin
        rpt.cpu_idle = 1'b1;
      end else begin
        rpt.ran_slot = pick[srts_pkg::SLOT_W-1:0];
        remaining_tab[pick] = remaining_tab[pick] - 1'b1;
        if (remaining_tab[pick] == '0) begin
          done = (tick_clock == '1) ? tick_clock : tick_clock + 1'b1;
          span = (done > arrival_tab[pick]) ? done - arrival_tab[pick] : '0;
          rpt.finished        = 1'b1;
          rpt.finished_slot   = pick[srts_pkg::SLOT_W-1:0];
          rpt.completion_time = done;
          rpt.turnaround_time = span;
          rpt.waiting_time    = (span > burst_tab[pick]) ? span - burst_tab[pick] : '0;
        end
      end
      if (tick_clock != '1) tick_clock = tick_clock + 1'b1;
    end
    pending_reports.insert(pending_reports.size(), rpt);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Match one accepted result against the oldest queued report.
  function void check_report(sched_report_t got);
    sched_report_t want;
    if (pending_reports.size() == 0) begin
      mismatches++;
      $error("result with no request outstanding: %h", got);
      return;
    end
    want = pending_reports.pop_front();
    compare_field("finished", want.finished, got.finished);
    compare_field("finished_slot", want.finished_slot, got.finished_slot);
    compare_field("completion_time", want.completion_time, got.completion_time);
    compare_field("waiting_time", want.waiting_time, got.waiting_time);
    compare_field("turnaround_time", want.turnaround_time, got.turnaround_time);
    compare_field("ran_slot", want.ran_slot, got.ran_slot);
    compare_field("cpu_idle", want.cpu_idle, got.cpu_idle);
  endfunction
endclass

module tb_shortest_remaining_time_scheduler_top;
  import srts_pkg::*;

  // Command code the block must treat as a no-op.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int          REQUESTS_PER_MODE = 275;
  // Allow a margin on top of the length of a tick for the tail.
  localparam int          TAIL_CYCLES       = SLOT_COUNT + 15;
  // Slowest run: about 1100 requests, each at most a tick plus idle gaps and
  // stalls; take it about ten times over.
  localparam int unsigned CYCLE_LIMIT       = 400_000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [CMD_W-1:0]   command;
  logic [SLOT_W-1:0]  slot;
  logic [TIME_W-1:0]  arrival_time;
  logic [TIME_W-1:0]  burst_time;
  logic               out_valid;
  logic               out_stall;
  logic               finished;
  logic [SLOT_W-1:0]  finished_slot;
  logic [TIME_W-1:0]  completion_time;
  logic [TIME_W-1:0]  waiting_time;
  logic [TIME_W-1:0]  turnaround_time;
  logic [SLOT_W-1:0]  ran_slot;
  logic               cpu_idle;

  sched_report_t      seen_report;
  schedule_tracker    tracker;
  int unsigned        send_idle_pct  = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        cycle_count    = 0;

  shortest_remaining_time_scheduler_top i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .slot            (slot),
    .arrival_time    (arrival_time),
    .burst_time      (burst_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .finished        (finished),
    .finished_slot   (finished_slot),
    .completion_time (completion_time),
    .waiting_time    (waiting_time),
    .turnaround_time (turnaround_time),
    .ran_slot        (ran_slot),
    .cpu_idle        (cpu_idle)
  );

  // 12 ns period, low half first.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Pack the result ports in field order so the tracker can compare them as one.
  assign seen_report = {finished, finished_slot, completion_time, waiting_time,
                        turnaround_time, ran_slot, cpu_idle};

  // Receiver: decide the stall for the next edge on each falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Take a result on every edge where it is offered and not held back.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_report(seen_report);
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_shortest_remaining_time_scheduler_top: FAIL");
      $finish;
    end
  end

  // Present one request and hold it until accepted. Called and left at a falling
  // edge; random idle cycles go in front of the request while the sender is idling.
  task automatic send_request(input logic [CMD_W-1:0]  cmd,
                              input logic [SLOT_W-1:0] sl,
                              input logic [TIME_W-1:0] arr,
                              input logic [TIME_W-1:0] bur);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    slot         <= sl;
    arrival_time <= arr;
    burst_time   <= bur;
    do @(posedge clk); while (in_stall);
    tracker.note_request(cmd, sl, arr, bur);
    @(negedge clk);
  endtask

  // Build a request that mostly keeps the table busy: short bursts arriving at or
  // near the current tick, with a tail of far arrivals, long bursts, clears and junk.
  task automatic random_request();
    int unsigned        roll;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  arr;
    logic [TIME_W-1:0]  bur;
    logic [SLOT_W-1:0]  sl;
    logic [CMD_W-1:0]   cmd;
    roll = $urandom_range(0, 99);
    now  = tracker.current_tick();
    sl   = SLOT_W'($urandom);
    arr  = TIME_W'($urandom);
    bur  = TIME_W'($urandom);
    if (roll < 2) begin
      cmd = CMD_UNUSED;
    end else if (roll < 5) begin
      cmd = CMD_CLEAR;
    end else if (roll < 42) begin
      cmd = CMD_LOAD;
      case ($urandom_range(0, 9))
        0: begin
          // keep the full-range arrival, usually far in the future
        end
        1, 2: arr = now - TIME_W'($urandom_range(0, 20));
        default: arr = now + TIME_W'($urandom_range(0, 4));
      endcase
      roll = $urandom_range(0, 19);
      if (roll == 0) bur = '0;
      else if (roll > 3) bur = TIME_W'($urandom_range(1, 6));
    end else begin
      cmd = CMD_TICK;
    end
    send_request(cmd, sl, arr, bur);
  endtask

  initial begin
    tracker        = new();
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    command       <= CMD_LOAD;
    slot          <= '0;
    arrival_time  <= '0;
    burst_time    <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: idle tick on an empty table, junk command with every bit set,
    // zero burst, tie to the lowest slot, reload of a busy slot, a future arrival,
    // preemption by a shorter newcomer, and a clear with stray fields.
    send_request(CMD_TICK,   4'd0,  16'd0,     16'd0);
    send_request(CMD_UNUSED, 4'hF,  16'hFFFF,  16'hFFFF);
    send_request(CMD_LOAD,   4'd0,  16'd0,     16'd0);
    send_request(CMD_LOAD,   4'd15, 16'd0,     16'd2);
    send_request(CMD_LOAD,   4'd1,  16'd0,     16'd2);
    send_request(CMD_LOAD,   4'd2,  16'hFFFF,  16'hFFFF);
    send_request(CMD_TICK,   4'd0,  16'd0,     16'd0);
    send_request(CMD_TICK,   4'd0,  16'd0,     16'd0);
    send_request(CMD_LOAD,   4'd15, 16'd3,     16'd1);
    send_request(CMD_TICK,   4'd0,  16'd0,     16'd0);
    send_request(CMD_LOAD,   4'd4,  16'd10,    16'd3);
    send_request(CMD_TICK,   4'hF,  16'hFFFF,  16'hFFFF);
    send_request(CMD_LOAD,   4'd6,  16'd0,     16'd5);
    send_request(CMD_TICK,   4'd0,  16'd0,     16'd0);
    send_request(CMD_TICK,   4'd0,  16'd0,     16'd0);
    send_request(CMD_LOAD,   4'd7,  16'd7,     16'd1);
    send_request(CMD_TICK,   4'd0,  16'd0,     16'd0);
    send_request(CMD_TICK,   4'd0,  16'd0,     16'd0);
    send_request(CMD_TICK,   4'd0,  16'd0,     16'd0);
    send_request(CMD_CLEAR,  4'hA,  16'h5A5A,  16'hA5A5);
    send_request(CMD_TICK,   4'd0,  16'd0,     16'd0);

    // Random traffic in four modes: free flow, sender idling, receiver stalling,
    // then both at a lighter rate.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct  = 23;
          recv_stall_pct = 23;
        end
      endcase
      repeat (REQUESTS_PER_MODE) random_request();
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then give any stray result time to show up.
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
      $display("tb_shortest_remaining_time_scheduler_top: PASS");
    end else begin
      $display("tb_shortest_remaining_time_scheduler_top: FAIL");
    end
    $finish;
  end
endmodule
